FILE: design/tss_pkg.sv
package tss_pkg;

	// slot table geometry
	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int IDX_W      = 4;
	localparam int SP_W       = 32;
	localparam int ID_W       = 8;
	localparam int ST_W       = 2;
	localparam int POL_W      = 2;
	localparam int CNT_W      = 32;

	// policy codes
	localparam logic [POL_W-1:0] POL_RR   = 2'd0;
	localparam logic [POL_W-1:0] POL_LOW  = 2'd1;
	localparam logic [POL_W-1:0] POL_PRIO = 2'd2;
	localparam logic [POL_W-1:0] POL_BAD  = 2'd3;

	// thread status codes
	localparam logic [ST_W-1:0] TS_IDLE    = 2'd0;
	localparam logic [ST_W-1:0] TS_READY   = 2'd1;
	localparam logic [ST_W-1:0] TS_RUNNING = 2'd2;

	// item function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [SP_W-1:0]   sp_t;
	typedef logic [ST_W-1:0]   status_t;

	// scan request from the sequencer
	typedef struct packed {
		logic  go;
		logic  prio_mode;
		logic  base_valid;
		slot_t base;
	} scan_req_t;

	// scan outcome, held while done pulses
	typedef struct packed {
		logic  done;
		logic  found;
		slot_t best;
	} scan_res_t;

	// per slot data seen by the scan unit
	typedef struct packed {
		logic ready;
		id_t  id;
	} slot_rd_t;

	// slot table write controls
	typedef struct packed {
		logic    load_we;
		logic    save_we;
		logic    run_we;
		slot_t   idx;
		logic    present;
		status_t status;
		id_t     id;
		sp_t     sp;
	} tbl_wr_t;

endpackage

FILE: design/tss_table.sv
module tss_table (
	input  logic             clk,
	input  logic             arst_n,
	input  tss_pkg::tbl_wr_t wr,
	input  tss_pkg::slot_t   scan_idx,
	output tss_pkg::slot_rd_t scan_rd,
	input  tss_pkg::slot_t   sp_idx,
	output tss_pkg::sp_t     sp_rd
);
	import tss_pkg::*;

	logic    valid_q  [SLOT_COUNT];
	status_t status_q [SLOT_COUNT];
	id_t     id_q     [SLOT_COUNT];
	sp_t     stack_q  [SLOT_COUNT];

	// present flags and status, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				valid_q[i]  <= 1'b0;
				status_q[i] <= TS_IDLE;
			end
		end else begin
			if (wr.load_we) begin
				valid_q[wr.idx]  <= wr.present;
				status_q[wr.idx] <= wr.status;
			end else if (wr.save_we) begin
				if (valid_q[wr.idx] && status_q[wr.idx] == TS_RUNNING) begin
					status_q[wr.idx] <= TS_READY;
				end
			end else if (wr.run_we) begin
				status_q[wr.idx] <= TS_RUNNING;
			end
		end
	end

	// priority ids and saved stack pointers, undefined until loaded
	always_ff @(posedge clk) begin
		if (wr.load_we) begin
			id_q[wr.idx]    <= wr.id;
			stack_q[wr.idx] <= wr.sp;
		end else if (wr.save_we && valid_q[wr.idx]) begin
			stack_q[wr.idx] <= wr.sp;
		end
	end

	// read ports
	assign scan_rd.ready = valid_q[scan_idx] && status_q[scan_idx] == TS_READY;
	assign scan_rd.id    = id_q[scan_idx];
	assign sp_rd         = stack_q[sp_idx];

endmodule

FILE: design/tss_scan.sv
module tss_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  tss_pkg::scan_req_t req,
	output tss_pkg::slot_t     rd_idx,
	input  tss_pkg::slot_rd_t  rd,
	output tss_pkg::scan_res_t res
);
	import tss_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              found_q;
	logic              prio_q;
	logic              base_valid_q;
	slot_t             base_q;
	slot_t             cnt_q;
	slot_t             best_q;
	id_t               best_id_q;
	logic [SLOT_W:0]   wrap_sum;
	logic              take;
	logic              last;

	// slot visited this cycle, round robin starts after the base slot
	always_comb begin
		wrap_sum = {1'b0, base_q} + (SLOT_W+1)'(1) + {1'b0, cnt_q};
		if (wrap_sum >= (SLOT_W+1)'(SLOT_COUNT)) begin
			wrap_sum = wrap_sum - (SLOT_W+1)'(SLOT_COUNT);
		end
		rd_idx = base_valid_q ? wrap_sum[SLOT_W-1:0] : cnt_q;
	end

	// shared compare: first ready slot, or strictly lower id in priority mode
	assign take = rd.ready && (!found_q || (prio_q && rd.id < best_id_q));
	assign last = cnt_q == SLOT_W'(SLOT_COUNT - 1);

	// scan sequencer, one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			prio_q       <= 1'b0;
			base_valid_q <= 1'b0;
			base_q       <= '0;
			cnt_q        <= '0;
			best_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q       <= 1'b1;
				found_q      <= 1'b0;
				prio_q       <= req.prio_mode;
				base_valid_q <= req.base_valid;
				base_q       <= req.base;
				cnt_q        <= '0;
				best_q       <= '0;
			end else if (busy_q) begin
				if (take) begin
					found_q <= 1'b1;
					best_q  <= rd_idx;
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + SLOT_W'(1);
				end
			end
		end
	end

	// best id rides along with the best slot
	always_ff @(posedge clk) begin
		if (busy_q && take) begin
			best_id_q <= rd.id;
		end
	end

	assign res.done  = done_q;
	assign res.found = found_q;
	assign res.best  = best_q;

endmodule

FILE: design/thread_slot_scheduler.sv
// channel   | transaction rule               | ports
// ----------+--------------------------------+-------------------------------------------
// command   | start & !busy at clock edge     | func, stack_pointer, slot_index,
//           |                                | load_present, load_status, load_id
// result    | done high for one cycle         | resume_sp, chosen_slot, chosen_valid,
//           |                                | switched, switch_total
// config    | cfg_valid & cfg_ready           | cfg_data (policy)
//
// a load raises done in the cycle after the accepting edge and busy stays low.
// a tick first writes back the interrupted stack pointer in the save state, then the
// shared compare unit visits one slot per cycle, and the scan state commits the
// choice once the scan is done; busy is high for all of it.
// arst_n clears status, present flags, current slot, switch count and policy.
// results cannot be held off; cfg_ready is always high.
module thread_slot_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [31:0]                 stack_pointer,
	input  logic [3:0]                  slot_index,
	input  logic                        load_present,
	input  logic [1:0]                  load_status,
	input  logic [7:0]                  load_id,
	output logic                        done,
	output logic [31:0]                 resume_sp,
	output logic [3:0]                  chosen_slot,
	output logic                        chosen_valid,
	output logic                        switched,
	output logic [31:0]                 switch_total,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_data
);
	import tss_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SAVE = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0]        state_q;
	logic [POL_W-1:0]  policy_q;
	sp_t               sp_q;
	slot_t             cur_q;
	logic              cur_valid_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	sp_t               resume_sp_q;
	logic [IDX_W-1:0]  chosen_slot_q;
	logic              chosen_valid_q;
	logic              switched_q;
	logic [CNT_W-1:0]  switch_total_q;

	logic              accept;
	logic              in_range;
	logic              sw;
	tbl_wr_t           wr;
	scan_req_t         req;
	scan_res_t         res;
	slot_t             scan_idx;
	slot_rd_t          scan_rd;
	sp_t               sp_rd;

	assign accept    = start && !busy;
	assign in_range  = 32'(slot_index) < SLOT_COUNT;
	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign sw        = !cur_valid_q || res.best != cur_q;

	// table write controls per state
	always_comb begin
		wr         = '0;
		wr.present = load_present;
		wr.status  = load_status;
		wr.id      = load_id;
		wr.sp      = stack_pointer;
		wr.idx     = SLOT_W'(slot_index);
		unique case (state_q)
			S_IDLE: begin
				wr.load_we = accept && func == FUNC_LOAD && in_range;
			end
			S_SAVE: begin
				wr.save_we = cur_valid_q;
				wr.idx     = cur_q;
				wr.sp      = sp_q;
			end
			S_SCAN: begin
				wr.run_we = res.done && res.found;
				wr.idx    = res.best;
			end
			default: begin
				wr.load_we = 1'b0;
			end
		endcase
	end

	// scan request issued as the save completes
	always_comb begin
		req.go         = state_q == S_SAVE;
		req.prio_mode  = policy_q == POL_PRIO;
		req.base_valid = cur_valid_q && policy_q == POL_RR;
		req.base       = cur_q;
	end

	tss_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.scan_idx (scan_idx),
		.scan_rd  (scan_rd),
		.sp_idx   (res.best),
		.sp_rd    (sp_rd)
	);

	tss_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_idx (scan_idx),
		.rd     (scan_rd),
		.res    (res)
	);

	// policy register, the unused code is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RR;
		end else if (cfg_valid && cfg_ready && cfg_data != POL_BAD) begin
			policy_q <= cfg_data;
		end
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_LOAD) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_SAVE;
						end
					end
				end
				S_SAVE: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (res.done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (res.found) begin
							cur_q       <= res.best;
							cur_valid_q <= 1'b1;
							count_q     <= count_q + CNT_W'(sw);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// latched tick stack pointer and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sp_q <= stack_pointer;
		end
		if (state_q == S_IDLE && accept && func == FUNC_LOAD) begin
			resume_sp_q    <= '0;
			chosen_slot_q  <= '0;
			chosen_valid_q <= 1'b0;
			switched_q     <= 1'b0;
			switch_total_q <= count_q;
		end else if (state_q == S_SCAN && res.done) begin
			if (res.found) begin
				resume_sp_q    <= sp_rd;
				chosen_slot_q  <= IDX_W'(res.best);
				chosen_valid_q <= 1'b1;
				switched_q     <= sw;
				switch_total_q <= count_q + CNT_W'(sw);
			end else begin
				resume_sp_q    <= sp_q;
				chosen_slot_q  <= '0;
				chosen_valid_q <= 1'b0;
				switched_q     <= 1'b0;
				switch_total_q <= count_q;
			end
		end
	end

	assign done         = done_q;
	assign resume_sp    = resume_sp_q;
	assign chosen_slot  = chosen_slot_q;
	assign chosen_valid = chosen_valid_q;
	assign switched     = switched_q;
	assign switch_total = switch_total_q;

endmodule

FILE: verif/thread_slot_scheduler_tb.sv
module thread_slot_scheduler_tb;

	import tss_pkg::*;

	// expected content of one result transaction
	typedef struct {
		sp_t                resume_sp;
		slot_t              chosen_slot;
		logic               chosen_valid;
		logic               switched;
		logic [CNT_W-1:0]   switch_total;
	} resume_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               func;
	logic [31:0]        stack_pointer;
	logic [3:0]         slot_index;
	logic               load_present;
	logic [1:0]         load_status;
	logic [7:0]         load_id;
	logic               done;
	logic [31:0]        resume_sp;
	logic [3:0]         chosen_slot;
	logic               chosen_valid;
	logic               switched;
	logic [31:0]        switch_total;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_data;

	// scheduler state as the testbench expects it
	logic               tbl_present [SLOT_COUNT];
	status_t            tbl_status  [SLOT_COUNT];
	id_t                tbl_id      [SLOT_COUNT];
	sp_t                tbl_sp      [SLOT_COUNT];
	slot_t              cur_slot;
	logic               cur_valid;
	logic [CNT_W-1:0]   sw_count;
	logic [POL_W-1:0]   policy_reg;

	resume_t            resume_q [$];
	resume_t            resume_exp;
	int                 err_count;
	int                 items_sent;
	int                 ticks_sent;
	int                 chosen_seen;
	int                 idle_pct;

	thread_slot_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.stack_pointer (stack_pointer),
		.slot_index    (slot_index),
		.load_present  (load_present),
		.load_status   (load_status),
		.load_id       (load_id),
		.done          (done),
		.resume_sp     (resume_sp),
		.chosen_slot   (chosen_slot),
		.chosen_valid  (chosen_valid),
		.switched      (switched),
		.switch_total  (switch_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mismatch reporting
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	function automatic bit slot_ready(input int i);
		return tbl_present[i] && tbl_status[i] == TS_READY;
	endfunction

	// pick the next ready slot under the active policy, -1 if none
	function automatic int pick_slot();
		int best;
		int i;
		best = -1;
		if (policy_reg == POL_LOW) begin
			for (i = 0; i < SLOT_COUNT; i++)
				if (best < 0 && slot_ready(i))
					best = i;
		end else if (policy_reg == POL_PRIO) begin
			for (i = 0; i < SLOT_COUNT; i++)
				if (slot_ready(i) && (best < 0 || tbl_id[i] < tbl_id[best]))
					best = i;
		end else begin
			for (int off = 1; off <= SLOT_COUNT; off++) begin
				i = cur_valid ? (int'(cur_slot) + off) % SLOT_COUNT : off - 1;
				if (best < 0 && slot_ready(i))
					best = i;
			end
		end
		return best;
	endfunction

	// advance the expected state by one accepted transaction
	task automatic schedule_step(input logic f, input sp_t sp, input slot_t idx,
		input logic pres, input status_t st, input id_t id);
		resume_t r;
		int pick;
		r = '{default: '0};
		if (f == FUNC_LOAD) begin
			tbl_present[idx] = pres;
			tbl_status[idx]  = st;
			tbl_id[idx]      = id;
			tbl_sp[idx]      = sp;
			r.switch_total   = sw_count;
		end else begin
			// preempted thread keeps its stack and goes back to ready
			if (cur_valid && tbl_present[cur_slot]) begin
				tbl_sp[cur_slot] = sp;
				if (tbl_status[cur_slot] == TS_RUNNING)
					tbl_status[cur_slot] = TS_READY;
			end
			pick = pick_slot();
			if (pick < 0) begin
				r.resume_sp    = sp;
				r.switch_total = sw_count;
			end else begin
				r.switched = !cur_valid || slot_t'(pick) != cur_slot;
				if (r.switched)
					sw_count++;
				cur_slot          = slot_t'(pick);
				cur_valid         = 1'b1;
				tbl_status[pick]  = TS_RUNNING;
				r.resume_sp       = tbl_sp[pick];
				r.chosen_slot     = slot_t'(pick);
				r.chosen_valid    = 1'b1;
				r.switch_total    = sw_count;
			end
		end
		resume_q.push_back(r);
	endtask

	// drive one command transaction, starting and ending at a falling edge
	task automatic send_item(input logic f, input sp_t sp, input slot_t idx,
		input logic pres, input status_t st, input id_t id);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		func          = f;
		stack_pointer = sp;
		slot_index    = idx;
		load_present  = pres;
		load_status   = st;
		load_id       = id;
		start         = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		schedule_step(f, sp, idx, pres, st, id);
		items_sent++;
		if (f == FUNC_TICK)
			ticks_sent++;
		@(negedge clk);
	endtask

	// hold off commands until every pending result is back, then let the block settle
	task automatic wait_results_drained();
		start = 1'b0;
		while (resume_q.size() != 0)
			@(negedge clk);
		repeat (SLOT_COUNT + 8) @(negedge clk);
	endtask

	// policy register write while the block is idle
	task automatic set_policy(input logic [POL_W-1:0] v);
		wait_results_drained();
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (v != POL_BAD)
			policy_reg = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// result checking
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (resume_q.size() == 0) begin
				report_mismatch("result with no transaction pending", resume_sp, 0);
			end else begin
				resume_exp = resume_q.pop_front();
				if (resume_sp !== resume_exp.resume_sp)
					report_mismatch("resume_sp", resume_sp, resume_exp.resume_sp);
				if (chosen_slot !== resume_exp.chosen_slot)
					report_mismatch("chosen_slot", 32'(chosen_slot),
						32'(resume_exp.chosen_slot));
				if (chosen_valid !== resume_exp.chosen_valid)
					report_mismatch("chosen_valid", 32'(chosen_valid),
						32'(resume_exp.chosen_valid));
				if (switched !== resume_exp.switched)
					report_mismatch("switched", 32'(switched), 32'(resume_exp.switched));
				if (switch_total !== resume_exp.switch_total)
					report_mismatch("switch_total", switch_total, resume_exp.switch_total);
				if (chosen_valid === 1'b1)
					chosen_seen++;
			end
		end
	end

	// empty table: tick falls through, then a load with extreme fields
	task automatic test_empty_table();
		send_item(FUNC_TICK, 32'hFFFF_FFFF, 4'd0, 1'b0, TS_IDLE, 8'd0);
		send_item(FUNC_LOAD, 32'h0000_0000, 4'd0, 1'b1, TS_READY, 8'hFF);
	endtask

	// round robin from no current thread, skipping running and status three slots
	task automatic test_round_robin();
		send_item(FUNC_LOAD, 32'hFFFF_FFFF, 4'd15, 1'b1, TS_READY, 8'd0);
		send_item(FUNC_LOAD, 32'h5555_5555, 4'd5, 1'b1, TS_RUNNING, 8'd1);
		send_item(FUNC_LOAD, 32'h7777_7777, 4'd7, 1'b1, status_t'(3), 8'd1);
		send_item(FUNC_TICK, 32'h0000_1111, 4'd0, 1'b0, TS_IDLE, 8'd0);
		send_item(FUNC_TICK, 32'hA5A5_A5A5, 4'd0, 1'b0, TS_IDLE, 8'd0);
		send_item(FUNC_TICK, 32'h0000_0001, 4'd0, 1'b0, TS_IDLE, 8'd0);
		send_item(FUNC_TICK, 32'h0000_0002, 4'd0, 1'b0, TS_IDLE, 8'd0);
	endtask

	// current slot removed: no save, scan still starts after it; then a self reschedule
	task automatic test_absent_current();
		send_item(FUNC_LOAD, 32'h0000_0000, 4'd15, 1'b0, TS_READY, 8'd0);
		send_item(FUNC_TICK, 32'h0000_0003, 4'd0, 1'b0, TS_IDLE, 8'd0);
		send_item(FUNC_TICK, 32'h0000_0004, 4'd0, 1'b0, TS_IDLE, 8'd0);
	endtask

	// lowest index, priority with a tie, ignored write of the bad code, back to round robin
	task automatic test_policy_modes();
		set_policy(POL_LOW);
		send_item(FUNC_LOAD, 32'h3333_3333, 4'd3, 1'b1, TS_READY, 8'd9);
		send_item(FUNC_LOAD, 32'h9999_9999, 4'd9, 1'b1, TS_READY, 8'd2);
		send_item(FUNC_LOAD, 32'hCCCC_CCCC, 4'd12, 1'b1, TS_READY, 8'd2);
		send_item(FUNC_TICK, 32'h0000_0010, 4'd0, 1'b0, TS_IDLE, 8'd0);
		set_policy(POL_PRIO);
		send_item(FUNC_TICK, 32'h0000_0020, 4'd0, 1'b0, TS_IDLE, 8'd0);
		send_item(FUNC_TICK, 32'h0000_0030, 4'd0, 1'b0, TS_IDLE, 8'd0);
		set_policy(POL_BAD);
		send_item(FUNC_TICK, 32'h0000_0040, 4'd0, 1'b0, TS_IDLE, 8'd0);
		set_policy(POL_RR);
		send_item(FUNC_TICK, 32'h0000_0050, 4'd0, 1'b0, TS_IDLE, 8'd0);
	endtask

	// mixed loads and ticks, policy rewritten every hundred transactions
	task automatic test_random_traffic(input int count, input int pct);
		logic    f;
		logic    pres;
		status_t st;
		id_t     id;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 50)
				set_policy(POL_W'($urandom_range(POL_RR, POL_BAD)));
			f = ($urandom_range(99) < 40) ? FUNC_TICK : FUNC_LOAD;
			// mostly runnable threads, the rest absent or not runnable
			if ($urandom_range(99) < 80) begin
				pres = 1'b1;
				st   = ($urandom_range(99) < 80) ? TS_READY : TS_RUNNING;
			end else begin
				pres = 1'($urandom_range(1));
				st   = status_t'($urandom_range(3));
			end
			// small ids often, so priority ties happen
			id = ($urandom_range(1) != 0) ? id_t'($urandom_range(3)) : id_t'($urandom);
			send_item(f, $urandom, slot_t'($urandom_range(SLOT_COUNT - 1)), pres, st, id);
		end
	endtask

	// main sequence
	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		func          = FUNC_TICK;
		stack_pointer = '0;
		slot_index    = '0;
		load_present  = 1'b0;
		load_status   = TS_IDLE;
		load_id       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = POL_RR;
		err_count     = 0;
		items_sent    = 0;
		ticks_sent    = 0;
		chosen_seen   = 0;
		idle_pct      = 16;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			tbl_present[i] = 1'b0;
			tbl_status[i]  = TS_IDLE;
			tbl_id[i]      = '0;
			tbl_sp[i]      = '0;
		end
		cur_slot   = '0;
		cur_valid  = 1'b0;
		sw_count   = '0;
		policy_reg = POL_RR;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_round_robin();
		test_absent_current();
		test_policy_modes();
		test_random_traffic(400, 16);
		test_random_traffic(400, 80);
		test_random_traffic(400, 0);

		wait_results_drained();
		if (resume_q.size() != 0)
			report_mismatch("results missing", 0, resume_q.size());
		$display("sent %0d transactions, %0d of them ticks, %0d picked a thread",
			items_sent, ticks_sent, chosen_seen);
		$display("all three policies plus the rejected code, with and without sender gaps");
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: thread_slot_scheduler.f
design/tss_pkg.sv
design/tss_table.sv
design/tss_scan.sv
design/thread_slot_scheduler.sv
verif/thread_slot_scheduler_tb.sv
